[rtl/pli_pkg.sv]
package pli_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 16;
  localparam int CFG_W       = 5;
  localparam int STEP_W      = $clog2(DATA_W);

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_CONVERT = 1'b1;

  // Search token that walks along the row of point cells.
  typedef struct packed {
    logic [DATA_W-1:0] query;
    logic              done;     // segment or clamp already decided
    logic              direct;   // r_cmd is the final answer
    logic [DATA_W-1:0] r_cmd;    // final answer, or lower command of the segment
    logic [DATA_W-1:0] lo_meas;
    logic [DATA_W-1:0] hi_cmd;
    logic [DATA_W-1:0] hi_meas;
  } srch_t;

endpackage

[rtl/pli_cell.sv]
module pli_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [pli_pkg::DATA_W-1:0] wr_cmd,
  input  logic [pli_pkg::DATA_W-1:0] wr_meas,
  input  logic [pli_pkg::CNT_W-1:0]  cell_index,
  input  logic                       is_first,
  input  logic [pli_pkg::CNT_W-1:0]  n_active,
  input  logic [pli_pkg::DATA_W-1:0] prev_cmd,
  input  logic [pli_pkg::DATA_W-1:0] prev_meas,
  input  logic                       tok_in_valid,
  input  pli_pkg::srch_t             tok_in,
  output logic [pli_pkg::DATA_W-1:0] cur_cmd,
  output logic [pli_pkg::DATA_W-1:0] cur_meas,
  output logic                       tok_out_valid,
  output pli_pkg::srch_t             tok_out
);
  import pli_pkg::*;

  srch_t tok_next;

  // The cell's own calibration point.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cur_cmd  <= wr_cmd;
      cur_meas <= wr_meas;
    end
  end

  // The first cell clamps below the table; every other cell closes the
  // segment that ends at its own point, or clamps past the last point in use.
  always_comb begin
    tok_next = tok_in;
    if (!tok_in.done) begin
      if (is_first) begin
        if (cur_meas > tok_in.query) begin
          tok_next.done   = 1'b1;
          tok_next.direct = 1'b1;
          tok_next.r_cmd  = cur_cmd;
        end
      end else if (cell_index >= n_active) begin
        tok_next.done   = 1'b1;
        tok_next.direct = 1'b1;
        tok_next.r_cmd  = prev_cmd;
      end else if (cur_meas >= tok_in.query) begin
        tok_next.done    = 1'b1;
        tok_next.direct  = 1'b0;
        tok_next.r_cmd   = prev_cmd;
        tok_next.lo_meas = prev_meas;
        tok_next.hi_cmd  = cur_cmd;
        tok_next.hi_meas = cur_meas;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out_valid <= 1'b0;
    end else begin
      tok_out_valid <= tok_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
  end

endmodule

[rtl/pli_div.sv]
module pli_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  pli_pkg::srch_t             seg,
  output logic                       done,
  output logic [pli_pkg::DATA_W-1:0] result
);
  import pli_pkg::*;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_MUL  = 2'd1;
  localparam logic [1:0] D_DIV  = 2'd2;
  localparam logic [1:0] D_OUT  = 2'd3;

  logic [1:0]          state;
  logic [DATA_W-1:0]   dx;
  logic [DATA_W-1:0]   mag;
  logic                neg;
  logic [DATA_W-1:0]   base;
  logic [DATA_W-1:0]   span;
  logic [DATA_W-1:0]   rem;
  logic [DATA_W-1:0]   quo;
  logic [STEP_W-1:0]   step;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W:0]     trial;
  logic                fits;

  assign prod  = dx * mag;
  assign trial = {rem, quo[DATA_W-1]};
  assign fits  = trial >= {1'b0, span};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == D_OUT);
      case (state)
        D_IDLE: begin
          if (start) begin
            state <= D_MUL;
          end
        end
        D_MUL: begin
          state <= D_DIV;
        end
        D_DIV: begin
          if (step == STEP_W'(DATA_W - 1)) begin
            state <= D_OUT;
          end
        end
        D_OUT: begin
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  // Magnitude product, restoring division one quotient bit per cycle, then
  // the sign is applied so that the quotient truncates toward zero.
  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        dx   <= seg.query - seg.lo_meas;
        neg  <= seg.hi_cmd < seg.r_cmd;
        mag  <= (seg.hi_cmd < seg.r_cmd) ? seg.r_cmd - seg.hi_cmd
                                         : seg.hi_cmd - seg.r_cmd;
        base <= seg.r_cmd;
        span <= seg.hi_meas - seg.lo_meas;
      end
      D_MUL: begin
        rem  <= prod[2*DATA_W-1:DATA_W];
        quo  <= prod[DATA_W-1:0];
        step <= '0;
      end
      D_DIV: begin
        rem  <= fits ? DATA_W'(trial - {1'b0, span}) : trial[DATA_W-1:0];
        quo  <= {quo[DATA_W-2:0], fits};
        step <= step + 1'b1;
      end
      D_OUT: begin
        result <= neg ? base - quo : base + quo;
      end
      default: begin
      end
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(state) == D_OUT)
    else $error("divider finished without passing its last step");
  assert property (@(posedge clk) disable iff (rst)
    (state == D_DIV) |-> (rem < span))
    else $error("division remainder not below the divisor");

endmodule

[rtl/piecewise_linear_inverse_map.sv]
// Piecewise-linear inverse map. A load beat (func 0) writes one calibration
// point into the cell for point_index and gives no result; a convert beat
// (func 1) maps query_value back to a command and gives one result beat on
// mapped_command. Each table slot sits in its own cell of a row of
// TABLE_DEPTH cells; a search token enters the first cell when the convert
// beat is taken and moves one cell per cycle, so the row has decided once
// the token leaves the last cell. A clamped result or a zero-width segment
// then goes straight to the output register. Otherwise the divider takes in
// the segment, forms the magnitude product, runs a restoring division and
// applies the sign, and the answer passes through res to the output
// register. A load leaves the block ready for the next beat. The block works
// on one convert at a time; loads are taken while a finished result still
// waits on the output register, and a result that is still waiting there
// holds the next finished convert back until it is taken. points_in_use is
// written on its own channel, which is always ready. It must be written only
// while the block is idle; the block itself does not enforce this. Values
// below two act as two and values above the table depth act as the depth.
// Slots that are read before they have ever been loaded give undefined
// answers.
module piecewise_linear_inverse_map (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       func,
  input  logic [pli_pkg::IDX_W-1:0]  point_index,
  input  logic [pli_pkg::DATA_W-1:0] point_command,
  input  logic [pli_pkg::DATA_W-1:0] point_measured,
  input  logic [pli_pkg::DATA_W-1:0] query_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pli_pkg::DATA_W-1:0] mapped_command,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pli_pkg::CFG_W-1:0]  points_in_use
);
  import pli_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state;
  logic [CFG_W-1:0]  pts_cfg;
  logic [CNT_W-1:0]  n_active;
  logic              in_beat;
  logic              conv_beat;
  srch_t             tok_launch;
  logic [DATA_W-1:0] res;

  logic [DATA_W-1:0] cmd_q  [TABLE_DEPTH];
  logic [DATA_W-1:0] meas_q [TABLE_DEPTH];
  srch_t             tok    [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tok_v;

  srch_t             tail;
  logic              tail_direct;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_res;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign conv_beat = in_beat && (func == FUNC_CONVERT);

  always_ff @(posedge clk) begin
    if (rst) begin
      pts_cfg <= CFG_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      pts_cfg <= points_in_use;
    end
  end

  // Number of points that take part, clamped to the legal range.
  always_comb begin
    if (pts_cfg < CFG_W'(2)) begin
      n_active = CNT_W'(2);
    end else if (int'(pts_cfg) > TABLE_DEPTH) begin
      n_active = CNT_W'(TABLE_DEPTH);
    end else begin
      n_active = CNT_W'(pts_cfg);
    end
  end

  always_comb begin
    tok_launch         = '0;
    tok_launch.query   = query_value;
  end

  genvar k;
  generate
    for (k = 0; k < TABLE_DEPTH; k++) begin : g_cell
      logic [DATA_W-1:0] p_cmd;
      logic [DATA_W-1:0] p_meas;
      logic              t_v;
      srch_t             t_in;

      if (k == 0) begin : g_head
        assign p_cmd  = '0;
        assign p_meas = '0;
        assign t_v    = conv_beat;
        assign t_in   = tok_launch;
      end else begin : g_body
        assign p_cmd  = cmd_q[k-1];
        assign p_meas = meas_q[k-1];
        assign t_v    = tok_v[k-1];
        assign t_in   = tok[k-1];
      end

      pli_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .wr_en        (in_beat && (func == FUNC_LOAD) && (point_index == IDX_W'(k))),
        .wr_cmd       (point_command),
        .wr_meas      (point_measured),
        .cell_index   (CNT_W'(k)),
        .is_first     (k == 0),
        .n_active     (n_active),
        .prev_cmd     (p_cmd),
        .prev_meas    (p_meas),
        .tok_in_valid (t_v),
        .tok_in       (t_in),
        .cur_cmd      (cmd_q[k]),
        .cur_meas     (meas_q[k]),
        .tok_out_valid(tok_v[k]),
        .tok_out      (tok[k])
      );
    end
  endgenerate

  // A token that left the row undecided means every point is in use and the
  // query lies past the last one.
  assign tail = tok[TABLE_DEPTH-1];
  assign tail_direct = !tail.done || tail.direct || (tail.hi_meas == tail.lo_meas);
  assign div_start = (state == S_SRCH) && tok_v[TABLE_DEPTH-1] && !tail_direct;

  pli_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .seg   (tail),
    .done  (div_done),
    .result(div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (conv_beat) begin
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (tok_v[TABLE_DEPTH-1]) begin
            state <= tail_direct ? S_DONE : S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The output register is loaded when a finished convert finds it free or
  // being emptied in the same cycle; otherwise a taken beat empties it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SRCH && tok_v[TABLE_DEPTH-1]) begin
      res <= tail.done ? tail.r_cmd : cmd_q[TABLE_DEPTH-1];
    end else if (state == S_DIV && div_done) begin
      res <= div_res;
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      mapped_command <= res;
    end
  end

  assert property (@(posedge clk) disable iff (rst) $onehot0(tok_v))
    else $error("more than one search token in the cell row");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> (tok_v == '0))
    else $error("block ready while a search token is still in the row");
  assert property (@(posedge clk) disable iff (rst) div_done |-> (state == S_DIV))
    else $error("divider result arrived outside the division phase");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE))
    else $error("result overwrote a beat not yet taken");

endmodule

[verif/tb_piecewise_linear_inverse_map.sv]
`timescale 1ns / 1ps

module tb_piecewise_linear_inverse_map;
  import pli_pkg::*;

  // The slowest correct run is far below this limit, counting every convert, the
  // sender gaps, short output stalls and a drain before each register write.
  localparam int LIMIT_CYCLES = 400000;
  // The drain after the last result has come back gives a load that is still being
  // absorbed time to finish before the block is treated as idle.
  localparam int DRAIN_CYCLES = 48;
  localparam int IDLE_PCT     = 6;
  localparam int PHASE_BEATS  = 160;

  // Keeps a copy of the calibration table and of the point count, and works out the
  // command that each convert beat should return. The expected commands wait in arrival
  // order until the block hands its results back.
  class calibration_checker;
    logic [DATA_W-1:0] cmd_pts [TABLE_DEPTH];
    logic [DATA_W-1:0] meas_pts [TABLE_DEPTH];
    bit                loaded [TABLE_DEPTH];
    logic [CFG_W-1:0]  pts_cfg;
    logic [DATA_W-1:0] due_cmds [$];
    logic [DATA_W-1:0] due_queries [$];
    int                errors;
    int                loads;
    int                converts;
    int                checked;

    function new();
      pts_cfg = CFG_W'(2);
    endfunction

    function int active_count();
      if (pts_cfg < 2) return 2;
      if (pts_cfg > TABLE_DEPTH) return TABLE_DEPTH;
      return int'(pts_cfg);
    endfunction

    // A convert may read any slot below the active point count. It is only issued when
    // every one of those slots has been loaded at least once.
    function bit table_ready();
      for (int i = 0; i < active_count(); i++) begin
        if (!loaded[i]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function int pending();
      return due_cmds.size();
    endfunction

    function logic [DATA_W-1:0] map_back(input logic [DATA_W-1:0] q);
      int     lo;
      int     n;
      longint span;
      longint dx;
      longint dy;
      longint val;
      n = active_count();
      if (meas_pts[0] > q) return cmd_pts[0];
      lo = 0;
      while (lo + 1 < n && meas_pts[lo + 1] < q) lo++;
      if (lo + 1 >= n) return cmd_pts[lo];
      span = longint'(meas_pts[lo + 1]) - longint'(meas_pts[lo]);
      if (span == 0) return cmd_pts[lo];
      dx  = longint'(q) - longint'(meas_pts[lo]);
      dy  = longint'(cmd_pts[lo + 1]) - longint'(cmd_pts[lo]);
      val = dx * dy / span + longint'(cmd_pts[lo]);
      return val[DATA_W-1:0];
    endfunction

    function void note_config(input logic [CFG_W-1:0] v);
      pts_cfg = v;
    endfunction

    function void note_beat(input logic f, input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] cmd, input logic [DATA_W-1:0] meas,
                            input logic [DATA_W-1:0] qv);
      if (f == FUNC_LOAD) begin
        cmd_pts[idx]  = cmd;
        meas_pts[idx] = meas;
        loaded[idx]   = 1'b1;
        loads++;
      end else begin
        due_cmds.push_back(map_back(qv));
        due_queries.push_back(qv);
        converts++;
      end
    endfunction

    task report(input string what);
      errors++;
      $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_command(input logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      logic [DATA_W-1:0] qv;
      if (due_cmds.size() == 0) begin
        report($sformatf("result %h arrived with no convert outstanding", got));
        return;
      end
      want = due_cmds.pop_front();
      qv   = due_queries.pop_front();
      checked++;
      if (got !== want)
        report($sformatf("query %h mapped to %h, expected %h", qv, got, want));
    endtask

    task check_drained();
      if (due_cmds.size() != 0)
        report($sformatf("%0d results never arrived", due_cmds.size()));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              func = FUNC_LOAD;
  logic [IDX_W-1:0]  point_index = '0;
  logic [DATA_W-1:0] point_command = '0;
  logic [DATA_W-1:0] point_measured = '0;
  logic [DATA_W-1:0] query_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] mapped_command;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  points_in_use = '0;

  calibration_checker sb;
  int                 beats;
  int                 cfg_writes;
  int                 cycles;
  // While set, neither side idles, so the block runs back to back for a long stretch.
  bit                 quiet;

  piecewise_linear_inverse_map DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .point_index    (point_index),
    .point_command  (point_command),
    .point_measured (point_measured),
    .query_value    (query_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .mapped_command (mapped_command),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .points_in_use  (points_in_use)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, sb.pending());
      $display("tb_piecewise_linear_inverse_map NOT OK");
      $finish;
    end
  end

  // Result side. The values seen here are those from before the edge, which are the ones
  // the block itself sampled, so a beat is counted exactly when it really moved. The
  // receiver then drops ready at random, with an IDLE_PCT percent chance, unless quiet is set.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_command(mapped_command);
    out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Offers one beat and returns at the edge that accepted it. Valid is left high, so a
  // following beat can go out on the very next cycle; the sender sometimes drops valid
  // first, which places gaps on every phase of a convert.
  task automatic send_beat(input logic f, input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] cmd, input logic [DATA_W-1:0] meas,
                           input logic [DATA_W-1:0] qv);
    quiet = (beats >= 700 && beats < 1000);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    func           <= f;
    point_index    <= idx;
    point_command  <= cmd;
    point_measured <= meas;
    query_value    <= qv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_beat(f, idx, cmd, meas, qv);
    beats++;
  endtask

  // The fields that a beat does not use still carry random data, so that the block is
  // seen to ignore them.
  task automatic put_load(input int idx, input logic [DATA_W-1:0] cmd,
                          input logic [DATA_W-1:0] meas);
    send_beat(FUNC_LOAD, IDX_W'(idx), cmd, meas, DATA_W'($urandom()));
  endtask

  task automatic put_query(input logic [DATA_W-1:0] qv);
    send_beat(FUNC_CONVERT, IDX_W'($urandom()), DATA_W'($urandom()), DATA_W'($urandom()), qv);
  endtask

  // Brings the block to rest: no beat on offer, every result returned, and time for a
  // trailing load to be absorbed.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_points(input logic [CFG_W-1:0] v);
    settle();
    cfg_valid     <= 1'b1;
    points_in_use <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(v);
    cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Commands and queries lean towards the ends of the range, where the slope and the
  // product are at their largest.
  function automatic logic [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return DATA_W'($urandom());
  endfunction

  // Loads the active points in ascending measured order, as software would. A narrow
  // spread of measured values makes repeated points, and so zero-width segments, common.
  task automatic load_sorted_table();
    int                n;
    int                spread;
    int                base;
    logic [DATA_W-1:0] m [$];
    n      = sb.active_count();
    spread = ($urandom_range(9) < 7) ? 65535 : $urandom_range(64, 1);
    base   = $urandom_range(65535 - spread);
    for (int i = 0; i < n; i++) m.push_back(DATA_W'(base + $urandom_range(spread)));
    m.sort();
    for (int i = 0; i < n; i++) put_load(i, pick_value(), m[i]);
  endtask

  // Queries aimed at the loaded points: on them, just beside them, inside a segment,
  // and beyond either end of the table.
  task automatic query_near_points();
    int                n;
    int                j;
    logic [DATA_W-1:0] q;
    n = sb.active_count();
    j = $urandom_range(n - 1);
    case ($urandom_range(6))
      0: q = DATA_W'($urandom());
      1: q = sb.meas_pts[j];
      2: q = sb.meas_pts[j] + ($urandom_range(1) ? DATA_W'(1) : '1);
      3: begin
        j = $urandom_range(n - 2);
        q = DATA_W'($urandom_range(sb.meas_pts[j], sb.meas_pts[j + 1]));
      end
      4: q = $urandom_range(1) ? '1 : '0;
      5: q = DATA_W'($urandom_range(sb.meas_pts[0]));
      default: q = DATA_W'($urandom_range(16'hFFFF, sb.meas_pts[n - 1]));
    endcase
    put_query(q);
  endtask

  initial begin
    int               pick;
    int               phase_end;
    logic [CFG_W-1:0] plan [10];
    plan = '{16, 0, 31, 1, 17, 2, 9, 24, 16, 5};
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed beats, all with the reset point count of two.
    // A falling table spanning the whole range: largest negative slope, extreme ends.
    put_load(0, 16'hFFFF, 16'h0000);
    put_load(1, 16'h0000, 16'hFFFF);
    put_query(16'h0000);
    put_query(16'hFFFF);
    put_query(16'h8000);
    put_query(16'h0001);
    // A rising segment: below the first point, on each point, inside, and past the last.
    put_load(0, 16'd100, 16'd1000);
    put_load(1, 16'd60000, 16'd2000);
    put_query(16'd0);
    put_query(16'd999);
    put_query(16'd1000);
    put_query(16'd1500);
    put_query(16'd2000);
    put_query(16'd2001);
    // Both points at the same measured value: the segment has no width.
    put_load(1, 16'd500, 16'd1000);
    put_query(16'd1000);
    put_query(16'd1001);
    put_query(16'd999);
    // Points loaded out of order.
    put_load(0, 16'd7, 16'd40000);
    put_load(1, 16'd9, 16'd100);
    put_query(16'd50000);
    put_query(16'd30000);

    // Random phases, each under its own point count. The counts include values below two
    // and above the table depth, which must act as the nearest legal count.
    foreach (plan[p]) begin
      write_points(plan[p]);
      phase_end = beats + PHASE_BEATS;
      while (beats < phase_end) begin
        pick = $urandom_range(99);
        if (!sb.table_ready() || pick < 25) begin
          load_sorted_table();
          repeat ($urandom_range(12, 3)) query_near_points();
        end else if (pick < 80) begin
          query_near_points();
        end else if (pick < 92) begin
          put_query(pick_value());
        end else begin
          // A stray load into any slot, which may leave the table unsorted.
          put_load($urandom_range(TABLE_DEPTH - 1), pick_value(), pick_value());
        end
      end
    end

    settle();
    sb.check_drained();
    $display("Run covered %0d loads and %0d converts; %0d results compared; %0d count writes.",
             sb.loads, sb.converts, sb.checked, cfg_writes);
    $display("Counts ran from below two to past the depth, with clamped, flat and unsorted data.");
    if (sb.errors == 0) begin
      $display("tb_piecewise_linear_inverse_map OK");
    end else begin
      $display("tb_piecewise_linear_inverse_map NOT OK");
    end
    $finish;
  end

endmodule
